@@ src/brfs_pkg.sv @@
// ---------------------------------------------------------------------------
// brfs_pkg: shared types for the byte ring FIFO with slots
// Operation codes, field widths and the command and response words.
// ---------------------------------------------------------------------------
`default_nettype none

package brfs_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 13;
    localparam int OFFSET_W = 12;
    localparam int LENGTH_W = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE_BYTE    = 3'd0,
        KIND_READ_BYTE     = 3'd1,
        KIND_PUTBACK_READ  = 3'd2,
        KIND_PUTBACK_WRITE = 3'd3,
        KIND_CLEAR         = 3'd4,
        KIND_WRITE_SLOT    = 3'd5,
        KIND_READ_SLOT     = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   write_byte;
        logic [COUNT_W-1:0]  count;
    } cmd_word_t;

    typedef struct packed {
        logic                done_res;
        logic [BYTE_W-1:0]   read_byte;
        logic [OFFSET_W-1:0] slot_offset;
        logic [LENGTH_W-1:0] slot_length;
        logic [LENGTH_W-1:0] occupancy;
        logic                is_full;
        logic                is_empty;
    } rsp_word_t;

endpackage : brfs_pkg

`default_nettype wire

@@ src/brfs_chan_if.sv @@
// ---------------------------------------------------------------------------
// brfs_chan_if: valid/ready channel
// Carries one word per handshake; the source drives valid and data.
// ---------------------------------------------------------------------------
`default_nettype none

interface brfs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : brfs_chan_if

`default_nettype wire

@@ src/byte_ring_fifo_with_slots_core.sv @@
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_slots_core: byte ring FIFO with slot reservation
// Power-of-two byte store with free-running 32-bit read and write counters.
// ---------------------------------------------------------------------------
// One command word is taken per clock while ready is high, and each one
// produces one response word. A command executes in the cycle it is accepted:
// counters and the store are updated at that edge and the store read port is
// registered; the response passes through the execute register and then the
// response register. Sustained rate is one word per cycle while the response
// side keeps taking words. When it stalls, one further command is still taken
// into the execute register, after which ready drops until the response is
// taken. CAPACITY must be a power of two; slot offsets and lengths above the
// response field widths are truncated. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_slots_core #(
    parameter int CAPACITY = 4096
) (
    input  wire logic clk,
    input  wire logic rst_n,
    brfs_chan_if.sink   cmd,
    brfs_chan_if.source rsp
);
    import brfs_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = AW + 1;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // Occupancy by the masked difference rule
    function automatic logic [LEN_W-1:0] occ_of(input logic [31:0] d);
        logic [LEN_W-1:0] res;
        if (d > 32'(CAPACITY))
        begin
            res = {1'b0, d[AW-1:0]};
        end
        else
        begin
            res = d[LEN_W-1:0];
        end
        return res;
    endfunction

    // Architectural state
    logic [31:0] wc_reg, wc_next;
    logic [31:0] rc_reg, rc_next;
    logic [31:0] diff_reg, diff_next;    // always wc_reg - rc_reg

    // Store
    logic [BYTE_W-1:0] mem [CAPACITY];
    logic [BYTE_W-1:0] rd_data_reg;

    // Execute register
    logic              p1_valid_reg;
    logic              p1_done_reg;
    logic              p1_rd_hit_reg;
    logic [AW-1:0]     p1_soff_reg;
    logic [LEN_W-1:0]  p1_slen_reg;
    logic [31:0]       p1_diff_reg;

    // Response register
    logic              out_valid_reg;
    rsp_word_t         out_data_reg;

    // Execute-stage decode
    logic [AW-1:0]     w, r;
    logic [LEN_W-1:0]  occ_now;
    logic              full_now, empty_now;
    logic              accept, p1_move;
    logic              we, re, done;
    logic [AW-1:0]     soff;
    logic [LEN_W-1:0]  slen;
    logic [31:0]       cnt_ext;
    logic [LEN_W-1:0]  occ_after;

    assign w         = wc_reg[AW-1:0];
    assign r         = rc_reg[AW-1:0];
    assign occ_now   = occ_of(diff_reg);
    assign full_now  = (occ_now == CAP_LEN);
    assign empty_now = (occ_now == '0);
    assign cnt_ext   = 32'(cmd.data.count);

    // Handshake: execute register frees when it moves to the response register
    assign p1_move   = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !p1_valid_reg || p1_move;
    assign accept    = cmd.valid && cmd.ready;

    // Execute one operation against the current counters
    always_comb
    begin
        wc_next   = wc_reg;
        rc_next   = rc_reg;
        diff_next = diff_reg;
        we        = 1'b0;
        re        = 1'b0;
        done      = 1'b0;
        soff      = '0;
        slen      = '0;
        unique case (cmd.data.kind)
            KIND_WRITE_BYTE:
            begin
                if (!full_now)
                begin
                    we        = 1'b1;
                    done      = 1'b1;
                    wc_next   = wc_reg + 32'd1;
                    diff_next = diff_reg + 32'd1;
                end
            end
            KIND_READ_BYTE:
            begin
                if (!empty_now)
                begin
                    re        = 1'b1;
                    done      = 1'b1;
                    rc_next   = rc_reg + 32'd1;
                    diff_next = diff_reg - 32'd1;
                end
            end
            KIND_PUTBACK_READ:
            begin
                rc_next   = rc_reg - cnt_ext;
                diff_next = diff_reg + cnt_ext;
            end
            KIND_PUTBACK_WRITE:
            begin
                wc_next   = wc_reg - cnt_ext;
                diff_next = diff_reg - cnt_ext;
            end
            KIND_CLEAR:
            begin
                rc_next   = wc_reg;
                diff_next = '0;
            end
            KIND_WRITE_SLOT:
            begin
                if (!full_now)
                begin
                    soff = w;
                    if (w >= r)
                    begin
                        slen = CAP_LEN - {1'b0, w};
                    end
                    else
                    begin
                        slen = {1'b0, r} - {1'b0, w};
                    end
                    wc_next   = wc_reg + 32'(slen);
                    diff_next = diff_reg + 32'(slen);
                end
            end
            KIND_READ_SLOT:
            begin
                soff = r;
                if (w > r)
                begin
                    slen = occ_now;
                end
                else if (w < r)
                begin
                    slen = CAP_LEN - {1'b0, r};
                end
                else if (wc_reg > rc_reg)
                begin
                    slen = CAP_LEN - {1'b0, r};
                end
                else
                begin
                    slen = '0;
                end
                rc_next   = rc_reg + 32'(slen);
                diff_next = diff_reg - 32'(slen);
            end
            default:
            begin
                // unused code: no state change
            end
        endcase
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && we)
        begin
            mem[w] <= cmd.data.write_byte;
        end
        if (accept && re)
        begin
            rd_data_reg <= mem[r];
        end
    end

    // Hold counters and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= '0;
            rc_reg        <= '0;
            diff_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wc_reg   <= wc_next;
                rc_reg   <= rc_next;
                diff_reg <= diff_next;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture execute results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_done_reg   <= done;
            p1_rd_hit_reg <= re;
            p1_soff_reg   <= soff;
            p1_slen_reg   <= slen;
            p1_diff_reg   <= diff_next;
        end
    end

    // Build the response word from the execute register
    assign occ_after = occ_of(p1_diff_reg);

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            out_data_reg.done_res    <= p1_done_reg;
            out_data_reg.read_byte   <= p1_rd_hit_reg ? rd_data_reg : '0;
            out_data_reg.slot_offset <= OFFSET_W'(p1_soff_reg);
            out_data_reg.slot_length <= LENGTH_W'(p1_slen_reg);
            out_data_reg.occupancy   <= LENGTH_W'(occ_after);
            out_data_reg.is_full     <= (occ_after == CAP_LEN);
            out_data_reg.is_empty    <= (occ_after == '0);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Difference tracker matches the counters
    a_diff_track: assert property (@(posedge clk) disable iff (!rst_n)
        diff_reg == wc_reg - rc_reg)
        else $error("occupancy tracker out of step with counters");

    // A granted byte write advances the write counter by one
    a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.data.kind == KIND_WRITE_BYTE && !full_now)
        |=> wc_reg == $past(wc_reg) + 32'd1)
        else $error("byte write did not advance write counter");

    // A nonzero read byte only comes with a completed operation
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.read_byte != '0) |-> rsp.data.done_res)
        else $error("read byte reported without completion");

endmodule : byte_ring_fifo_with_slots_core

`default_nettype wire

@@ tb/byte_ring_fifo_with_slots_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_ring_fifo_with_slots_core_test: self-checking bench for the byte ring
// Drives command words through the valid/ready channel and checks every
// response word against a local ring model. Stimulus opens with a short
// directed sequence and then runs a weighted random mix. Both sides idle at
// random, and the bench forces one long response stall and one full drain.
// ---------------------------------------------------------------------------

module byte_ring_fifo_with_slots_core_test;

    import brfs_pkg::*;

    localparam int    RING_DEPTH   = 4096;
    localparam int    RING_AW      = $clog2(RING_DEPTH);
    localparam int    RING_MASK    = RING_DEPTH - 1;
    localparam int    ITEM_TOTAL   = 1850;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    STALL_LIMIT  = 5000;
    localparam int    REPORT_LIMIT = 10;
    localparam kind_t KIND_SPARE   = kind_t'(3'd7);

    logic clk;
    logic rst_n;
    bit   calm;

    brfs_chan_if #(.payload_t(cmd_word_t)) cmd_ch ();
    brfs_chan_if #(.payload_t(rsp_word_t)) rsp_ch ();

    byte_ring_fifo_with_slots_core #(
        .CAPACITY (RING_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Ring model: counters, byte store and the queue of awaited responses
    class ring_scoreboard;
        logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
        bit                seen     [RING_DEPTH];
        bit [31:0]         rd_cnt = '0;
        bit [31:0]         wr_cnt = '0;
        rsp_word_t         due_q[$];
        int unsigned       mismatches = 0;
        int unsigned       checked = 0;

        function bit [31:0] held();
            bit [31:0] size;
            size = wr_cnt - rd_cnt;
            if (size > RING_DEPTH)
                size &= RING_MASK;
            return size;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // A byte read may only land on an entry that was written
        function bit read_ok();
            return held() == 0 || seen[rd_cnt[RING_AW-1:0]];
        endfunction

        // Apply one accepted command and queue the response it must produce
        function void note_cmd(cmd_word_t c);
            rsp_word_t e;
            bit [31:0] wi;
            bit [31:0] ri;
            bit [31:0] slen;
            bit [31:0] occ;
            wi   = wr_cnt & RING_MASK;
            ri   = rd_cnt & RING_MASK;
            slen = '0;
            e    = '0;
            case (c.kind)
                KIND_WRITE_BYTE:
                    if (held() != RING_DEPTH)
                    begin
                        ring_mem[wi[RING_AW-1:0]] = c.write_byte;
                        seen[wi[RING_AW-1:0]]     = 1'b1;
                        wr_cnt                    = wr_cnt + 1;
                        e.done_res                = 1'b1;
                    end
                KIND_READ_BYTE:
                    if (held() != 0)
                    begin
                        e.read_byte = ring_mem[ri[RING_AW-1:0]];
                        rd_cnt      = rd_cnt + 1;
                        e.done_res  = 1'b1;
                    end
                KIND_PUTBACK_READ:  rd_cnt = rd_cnt - c.count;
                KIND_PUTBACK_WRITE: wr_cnt = wr_cnt - c.count;
                KIND_CLEAR:         rd_cnt = wr_cnt;
                KIND_WRITE_SLOT:
                    if (held() != RING_DEPTH)
                    begin
                        slen          = (wi >= ri) ? RING_DEPTH - wi : ri - wi;
                        e.slot_offset = wi[OFFSET_W-1:0];
                        e.slot_length = slen[LENGTH_W-1:0];
                        wr_cnt        = wr_cnt + slen;
                    end
                KIND_READ_SLOT:
                begin
                    if (wi > ri)
                        slen = held();
                    else if (wi < ri)
                        slen = RING_DEPTH - ri;
                    else if (wr_cnt > rd_cnt)
                        slen = RING_DEPTH - ri;
                    e.slot_offset = ri[OFFSET_W-1:0];
                    e.slot_length = slen[LENGTH_W-1:0];
                    rd_cnt        = rd_cnt + slen;
                end
                default: ;
            endcase
            occ         = held();
            e.occupancy = occ[LENGTH_W-1:0];
            e.is_full   = (occ == RING_DEPTH);
            e.is_empty  = (occ == 0);
            due_q.push_back(e);
        endfunction

        // Compare one response with the oldest awaited one
        function void check_rsp(rsp_word_t got);
            rsp_word_t e;
            checked++;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response %0d arrived with nothing awaited", checked);
                return;
            end
            e = due_q.pop_front();
            if (got.done_res !== e.done_res || got.read_byte !== e.read_byte ||
                got.slot_offset !== e.slot_offset ||
                got.slot_length !== e.slot_length ||
                got.occupancy !== e.occupancy || got.is_full !== e.is_full ||
                got.is_empty !== e.is_empty)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("response %0d expected done=%0d byte=%02h off=%0d len=%0d",
                             checked, e.done_res, e.read_byte, e.slot_offset,
                             e.slot_length);
                    $display("    occ=%0d full=%0d empty=%0d", e.occupancy,
                             e.is_full, e.is_empty);
                    $display("  got done=%0d byte=%02h off=%0d len=%0d occ=%0d full=%0d empty=%0d",
                             got.done_res, got.read_byte, got.slot_offset,
                             got.slot_length, got.occupancy, got.is_full,
                             got.is_empty);
                end
            end
        endfunction
    endclass

    ring_scoreboard sb = new;

    // Clock and reset
    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic cmd_word_t mk_cmd(kind_t k, logic [BYTE_W-1:0] b,
                                         logic [COUNT_W-1:0] n);
        cmd_word_t c;
        c.kind       = k;
        c.write_byte = b;
        c.count      = n;
        return c;
    endfunction

    // Weighted mix: mostly byte traffic, some slots, putbacks, clears and unused codes
    function automatic cmd_word_t pick_cmd();
        int unsigned        roll;
        kind_t              k;
        logic [COUNT_W-1:0] n;
        roll = $urandom_range(99);
        if (roll < 32)      k = KIND_WRITE_BYTE;
        else if (roll < 60) k = KIND_READ_BYTE;
        else if (roll < 68) k = KIND_WRITE_SLOT;
        else if (roll < 76) k = KIND_READ_SLOT;
        else if (roll < 83) k = KIND_PUTBACK_READ;
        else if (roll < 90) k = KIND_PUTBACK_WRITE;
        else if (roll < 96) k = KIND_CLEAR;
        else                k = KIND_SPARE;
        if ($urandom_range(1))
            n = COUNT_W'($urandom_range(0, 16));
        else
            n = COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1));
        return mk_cmd(k, BYTE_W'($urandom_range(0, 255)), n);
    endfunction

    // Offer one word, hold until taken, then maybe idle with valid low
    task automatic push_cmd(input cmd_word_t word);
        cmd_word_t w;
        w = word;
        // steer a read away from a never-written entry
        if (w.kind == KIND_READ_BYTE && !sb.read_ok())
            w.kind = $urandom_range(1) ? KIND_READ_SLOT : KIND_CLEAR;
        cmd_ch.data  <= w;
        cmd_ch.valid <= 1'b1;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_cmd(w);
        if (!calm && $urandom_range(99) < 13)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        cmd_word_t plan[$];
        int        idx;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        calm         = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // empty refusal, byte round trip, putback re-read
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_WRITE_BYTE,    8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_WRITE_BYTE,    8'hFF, 13'h1FFF));
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_PUTBACK_READ,  8'h00, 13'd1));
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'h00, 13'd0));
        // fill through two write slots, then refusals when full
        plan.push_back(mk_cmd(KIND_WRITE_SLOT,    8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_WRITE_SLOT,    8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_WRITE_BYTE,    8'hAA, 13'd0));
        plan.push_back(mk_cmd(KIND_WRITE_SLOT,    8'h00, 13'd0));
        // read slots: equal positions while full, write ahead, then empty
        plan.push_back(mk_cmd(KIND_READ_SLOT,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_READ_SLOT,     8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_READ_SLOT,     8'h00, 13'd0));
        // wrap the write counter behind the read counter, masked occupancy
        plan.push_back(mk_cmd(KIND_PUTBACK_WRITE, 8'h00, 13'h1FFF));
        plan.push_back(mk_cmd(KIND_PUTBACK_READ,  8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_PUTBACK_READ,  8'h00, 13'd4096));
        plan.push_back(mk_cmd(KIND_CLEAR,         8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_SPARE,         8'hFF, 13'h1FFF));
        plan.push_back(mk_cmd(KIND_WRITE_BYTE,    8'h55, 13'h1FFF));
        plan.push_back(mk_cmd(KIND_READ_BYTE,     8'hFF, 13'h1FFF));
        plan.push_back(mk_cmd(KIND_WRITE_SLOT,    8'h00, 13'd0));
        plan.push_back(mk_cmd(KIND_READ_SLOT,     8'h00, 13'd0));

        foreach (plan[i])
            push_cmd(plan[i]);

        for (idx = plan.size(); idx < ITEM_TOTAL; idx++)
        begin
            calm = (idx >= 900 && idx < 1150);
            // drain completely once before carrying on
            if (idx == 1400)
            begin
                cmd_ch.valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            push_cmd(pick_cmd());
        end
        cmd_ch.valid <= 1'b0;

        // wait out the last responses plus the pipeline depth
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Response side: check each word, stall at random, one long hold-off
    initial
    begin
        bit held_once;
        held_once    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_ch.valid && rsp_ch.ready)
                    sb.check_rsp(rsp_ch.data);
                if (!held_once && sb.checked >= 600)
                begin
                    held_once = 1'b1;
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                rsp_ch.ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    // Watchdog: give up when no word moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
